// ----- design/eeg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_pkg: shared definitions for the extended Euclid gcd core
// Default operand width and the command/status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package eeg_pkg;

  localparam int OPERAND_WIDTH_DEF = 31;

  typedef struct packed {
    logic load;      // Capture and order a new pair of operands.
    logic div_step;  // One restoring division bit and one product bit.
    logic update;    // Retire a Euclid step into the remainder/coef registers.
  } eeg_cmd_t;

  typedef struct packed {
    logic rem_zero;  // The current remainder (divisor of the next step) is zero.
  } eeg_sts_t;

endpackage

// ----- design/eeg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_datapath: remainder and coefficient registers of extended Euclid
// Holds the running remainders and Bezout coefficients, a bit-serial
// restoring divider, and shift-and-add accumulators for quotient products.
// ----------------------------------------------------------------------------
module eeg_datapath #(
  parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  eeg_pkg::eeg_cmd_t         cmd_i,
  output eeg_pkg::eeg_sts_t         sts_o,
  input  logic [OPERAND_WIDTH-1:0]  first_operand_i,
  input  logic [OPERAND_WIDTH-1:0]  second_operand_i,
  output logic [OPERAND_WIDTH-1:0]  gcd_value_o,
  output logic signed [OPERAND_WIDTH:0] coef_larger_o,
  output logic signed [OPERAND_WIDTH:0] coef_smaller_o,
  output logic                      divide_error_o
);
  import eeg_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int C = OPERAND_WIDTH + 1;

  logic [W-1:0] r_old_q, r_old_d, r_cur_q, r_cur_d;
  logic [W-1:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [C-1:0] s_old_q, s_old_d, s_cur_q, s_cur_d;
  logic [C-1:0] t_old_q, t_old_d, t_cur_q, t_cur_d;
  logic [C-1:0] ps_q, ps_d, pt_q, pt_d;
  logic         err_q, err_d;

  logic [W-1:0] big, sml;
  logic [W:0]   trial, diff;
  logic         ge;
  logic [C-1:0] ps_sh, pt_sh, ps_add, pt_add;

  assign big = (second_operand_i > first_operand_i) ? second_operand_i : first_operand_i;
  assign sml = (second_operand_i > first_operand_i) ? first_operand_i : second_operand_i;

  // One restoring division bit: the borrow of the trial subtraction decides it.
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, r_cur_q};
  assign ge    = (trial >= {1'b0, r_cur_q});

  // The quotient products q*s_cur and q*t_cur are built MSB first, Horner style.
  assign ps_sh  = {ps_q[C-2:0], 1'b0};
  assign pt_sh  = {pt_q[C-2:0], 1'b0};
  assign ps_add = ps_sh + s_cur_q;
  assign pt_add = pt_sh + t_cur_q;

  always_comb begin
    r_old_d = r_old_q;
    r_cur_d = r_cur_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    s_old_d = s_old_q;
    s_cur_d = s_cur_q;
    t_old_d = t_old_q;
    t_cur_d = t_cur_q;
    ps_d    = ps_q;
    pt_d    = pt_q;
    err_d   = err_q;
    if (cmd_i.load) begin
      r_old_d = big;
      r_cur_d = sml;
      dvd_d   = big;
      rem_d   = '0;
      s_old_d = C'(1);
      s_cur_d = '0;
      t_old_d = '0;
      t_cur_d = C'(1);
      ps_d    = '0;
      pt_d    = '0;
      err_d   = (sml == '0);
    end else if (cmd_i.div_step) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      ps_d  = ge ? ps_add : ps_sh;
      pt_d  = ge ? pt_add : pt_sh;
    end else if (cmd_i.update) begin
      r_old_d = r_cur_q;
      r_cur_d = rem_q;
      dvd_d   = r_cur_q;
      rem_d   = '0;
      s_old_d = s_cur_q;
      s_cur_d = s_old_q - ps_q;
      t_old_d = t_cur_q;
      t_cur_d = t_old_q - pt_q;
      ps_d    = '0;
      pt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_old_q <= '0;
      r_cur_q <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      s_old_q <= '0;
      s_cur_q <= '0;
      t_old_q <= '0;
      t_cur_q <= '0;
      ps_q    <= '0;
      pt_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      r_old_q <= r_old_d;
      r_cur_q <= r_cur_d;
      rem_q   <= rem_d;
      dvd_q   <= dvd_d;
      s_old_q <= s_old_d;
      s_cur_q <= s_cur_d;
      t_old_q <= t_old_d;
      t_cur_q <= t_cur_d;
      ps_q    <= ps_d;
      pt_q    <= pt_d;
      err_q   <= err_d;
    end
  end

  assign sts_o.rem_zero = (r_cur_q == '0);

  // With a zero smaller operand every numeric field reads as zero.
  assign gcd_value_o    = err_q ? '0 : r_old_q;
  assign coef_larger_o  = err_q ? '0 : s_old_q;
  assign coef_smaller_o = err_q ? '0 : t_old_q;
  assign divide_error_o = err_q;

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (r_cur_q != '0))
    else $error("division step with a zero divisor");

endmodule

// ----- design/eeg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_ctrl: sequencer of the extended Euclid gcd core
// Steps the datapath through load, per-bit division and coefficient update
// until the remainder reaches zero, then strobes the result.
// ----------------------------------------------------------------------------
module eeg_ctrl #(
  parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output eeg_pkg::eeg_cmd_t cmd_o,
  input  eeg_pkg::eeg_sts_t sts_i
);
  import eeg_pkg::*;

  localparam int CntW = $clog2(OPERAND_WIDTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.rem_zero) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = CntW'(OPERAND_WIDTH - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_CHECK))
    else $error("accepted request did not start the chain");

  a_done_then_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("core stayed busy after the result strobe");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.update}))
    else $error("more than one datapath command at once");

endmodule

// ----- design/extended_euclid_gcd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_euclid_gcd_core: gcd with Bezout coefficients
// Sequence: after the edge that accepts the request the core runs n Euclid
//   division steps (at most 44 for 31-bit operands), each a check, a bit-serial
//   division and an update; a final check finds a zero remainder and done_o rises.
//   A zero smaller operand goes from the check straight to done. The bit-serial divider makes one quotient bit a cycle.
// Throughput: one request at a time; busy is low again the cycle after done_o.
// done_o is strobed for one cycle and cannot be stalled. Reset returns idle.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_core #(
  parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [OPERAND_WIDTH-1:0]      first_operand_i,
  input  logic [OPERAND_WIDTH-1:0]      second_operand_i,
  output logic                          done_o,
  output logic [OPERAND_WIDTH-1:0]      gcd_value_o,
  output logic signed [OPERAND_WIDTH:0] coef_larger_o,
  output logic signed [OPERAND_WIDTH:0] coef_smaller_o,
  output logic                          divide_error_o
);
  import eeg_pkg::*;

  eeg_cmd_t cmd;
  eeg_sts_t sts;

  eeg_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  eeg_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .gcd_value_o      (gcd_value_o),
    .coef_larger_o    (coef_larger_o),
    .coef_smaller_o   (coef_smaller_o),
    .divide_error_o   (divide_error_o)
  );

endmodule
